@@ sv/zwe_pkg.sv @@
package zwe_pkg;

   localparam int CODES_PER_ENTRY = 9;
   localparam int WORDS_PER_ENTRY = (CODES_PER_ENTRY / 3 > 3) ? 3 : CODES_PER_ENTRY / 3;
   localparam int COUNT_W = 4;
   localparam int ALPHA_LEN = 26;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;
   localparam int QUEUE_CNT_W = 3;

   localparam logic [4:0] SPACE_CODE = 5'd0;
   localparam logic [4:0] SHIFT_UPPER = 5'd4;
   localparam logic [4:0] SHIFT_PUNCT = 5'd5;
   localparam logic [4:0] PAD_CODE = 5'd5;
   localparam logic [4:0] ESCAPE_CODE = 5'd6;
   localparam logic [4:0] FIRST_CODE = 5'd6;
   localparam logic [7:0] SPACE_CHAR = 8'h20;

   // Default alphabet: A0 lowercase, A1 uppercase, A2 punctuation.
   // The first A2 slot is the escape position and never matches.
   localparam logic [7:0] ALPHABET_ROM [3 * ALPHA_LEN] = '{
      8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68, 8'h69, 8'h6a, 8'h6b, 8'h6c,
      8'h6d, 8'h6e, 8'h6f, 8'h70, 8'h71, 8'h72, 8'h73, 8'h74, 8'h75, 8'h76, 8'h77, 8'h78,
      8'h79, 8'h7a,
      8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4a, 8'h4b, 8'h4c,
      8'h4d, 8'h4e, 8'h4f, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54, 8'h55, 8'h56, 8'h57, 8'h58,
      8'h59, 8'h5a,
      8'h00, 8'h0a, 8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39,
      8'h2e, 8'h2c, 8'h21, 8'h3f, 8'h5f, 8'h23, 8'h27, 8'h22, 8'h2f, 8'h5c, 8'h2d, 8'h3a,
      8'h28, 8'h29
   };

   // One classified character: up to four codes, codes[0] first.
   typedef struct packed {
      logic [3:0][4:0] codes;
      logic [2:0]      num;
      logic            last;
   } zwe_class_type;

   function automatic zwe_class_type classify(logic [7:0] c, logic last);
      zwe_class_type r;
      logic          hit_lo;
      logic          hit_up;
      logic          hit_pu;
      logic [4:0]    idx_lo;
      logic [4:0]    idx_up;
      logic [4:0]    idx_pu;
      hit_lo = 1'b0;
      hit_up = 1'b0;
      hit_pu = 1'b0;
      idx_lo = '0;
      idx_up = '0;
      idx_pu = '0;
      for (int i = 0; i < ALPHA_LEN; i++) begin
         if (!hit_lo && ALPHABET_ROM[i] == c) begin
            hit_lo = 1'b1;
            idx_lo = 5'(i) + FIRST_CODE;
         end
         if (!hit_up && ALPHABET_ROM[ALPHA_LEN + i] == c) begin
            hit_up = 1'b1;
            idx_up = 5'(i) + FIRST_CODE;
         end
         if (i > 0 && !hit_pu && ALPHABET_ROM[2 * ALPHA_LEN + i] == c) begin
            hit_pu = 1'b1;
            idx_pu = 5'(i) + FIRST_CODE;
         end
      end
      // Anything not in the alphabet goes out as a ten-bit escape.
      r.codes[0] = SHIFT_PUNCT;
      r.codes[1] = ESCAPE_CODE;
      r.codes[2] = {2'b00, c[7:5]};
      r.codes[3] = c[4:0];
      r.num = 3'd4;
      r.last = last;
      if (c == SPACE_CHAR) begin
         r.codes[0] = SPACE_CODE;
         r.num = 3'd1;
      end else if (hit_lo) begin
         r.codes[0] = idx_lo;
         r.num = 3'd1;
      end else if (hit_up) begin
         r.codes[0] = SHIFT_UPPER;
         r.codes[1] = idx_up;
         r.num = 3'd2;
      end else if (hit_pu) begin
         r.codes[0] = SHIFT_PUNCT;
         r.codes[1] = idx_pu;
         r.num = 3'd2;
      end
      return r;
   endfunction

endpackage

@@ sv/zwe_if.sv @@
interface zwe_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       last_char;

   modport source(output valid, output char_code, output last_char, input ready);
   modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface zwe_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] packed_word;
   logic [1:0]  word_index;
   logic        last_word;

   modport source(output valid, output packed_word, output word_index, output last_word,
                  input ready);
   modport sink(input valid, input packed_word, input word_index, input last_word,
                output ready);
endinterface

@@ sv/zwe_front.sv @@
module zwe_front (
   zwe_req_if.sink              req_bus,
   output logic                 push_valid,
   output zwe_pkg::zwe_class_type push_data,
   input  logic                 push_ready
);

   assign push_valid = req_bus.valid;
   assign req_bus.ready = push_ready;
   assign push_data = zwe_pkg::classify(req_bus.char_code, req_bus.last_char);

endmodule

@@ sv/zwe_queue.sv @@
module zwe_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   input  zwe_pkg::zwe_class_type push_data,
   output logic                   push_ready,
   output logic                   pop_valid,
   output zwe_pkg::zwe_class_type pop_data,
   input  logic                   pop_ready
);

   zwe_pkg::zwe_class_type             entry_ff [zwe_pkg::QUEUE_DEPTH];
   logic [zwe_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [zwe_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [zwe_pkg::QUEUE_CNT_W-1:0]    fill_ff;
   logic                               do_push;
   logic                               do_pop;

   assign push_ready = fill_ff != zwe_pkg::QUEUE_CNT_W'(zwe_pkg::QUEUE_DEPTH);
   assign pop_valid = fill_ff != '0;
   assign pop_data = entry_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            fill_ff <= fill_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            fill_ff <= fill_ff - 1'b1;
         end
      end
   end

endmodule

@@ sv/zwe_back.sv @@
module zwe_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   input  zwe_pkg::zwe_class_type pop_data,
   output logic                   pop_ready,
   zwe_rsp_if.source              rsp_bus
);

   localparam int NSLOT = zwe_pkg::CODES_PER_ENTRY;
   localparam int NWORD = zwe_pkg::WORDS_PER_ENTRY;

   logic [4:0]                   buf_ff [NSLOT];
   logic [4:0]                   slot_in [NSLOT];
   logic [zwe_pkg::COUNT_W-1:0]  count_ff;
   logic [zwe_pkg::COUNT_W-1:0]  count_in;
   logic [zwe_pkg::COUNT_W:0]    count_sum;
   logic [14:0]                  emit_word_ff [NWORD];
   logic                         emit_active_ff;
   logic [1:0]                   emit_idx_ff;
   logic                         emit_last;
   logic                         take;
   logic                         out_free;
   logic                         load;
   logic                         rsp_valid_ff;
   logic [15:0]                  rsp_word_ff;
   logic [1:0]                   rsp_index_ff;
   logic                         rsp_last_ff;

   // A closing character has to wait until the previous entry's last word is in the output register.
   assign pop_ready = !pop_data.last || !emit_active_ff;
   assign take = pop_valid && pop_ready;

   // New contents of every slot: kept, newly appended, or padded on the last character.
   always_comb begin
      logic [zwe_pkg::COUNT_W:0] off;
      for (int k = 0; k < NSLOT; k++) begin
         off = (zwe_pkg::COUNT_W + 1)'(k) - {1'b0, count_ff};
         if ((zwe_pkg::COUNT_W + 1)'(k) < {1'b0, count_ff}) begin
            slot_in[k] = buf_ff[k];
         end else if (off < (zwe_pkg::COUNT_W + 1)'(pop_data.num)) begin
            slot_in[k] = pop_data.codes[off[1:0]];
         end else if (pop_data.last) begin
            slot_in[k] = zwe_pkg::PAD_CODE;
         end else begin
            slot_in[k] = buf_ff[k];
         end
      end
   end

   assign count_sum = {1'b0, count_ff} + (zwe_pkg::COUNT_W + 1)'(pop_data.num);
   assign count_in = (count_sum >= (zwe_pkg::COUNT_W + 1)'(NSLOT)) ?
                     zwe_pkg::COUNT_W'(NSLOT) : count_sum[zwe_pkg::COUNT_W-1:0];

   assign emit_last = emit_idx_ff == 2'(NWORD - 1);
   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign load = emit_active_ff && out_free;

   always_ff @(posedge clock) begin
      if (take && !pop_data.last) begin
         for (int k = 0; k < NSLOT; k++) begin
            buf_ff[k] <= slot_in[k];
         end
      end
      if (take && pop_data.last) begin
         for (int w = 0; w < NWORD; w++) begin
            emit_word_ff[w] <= {slot_in[3 * w], slot_in[3 * w + 1], slot_in[3 * w + 2]};
         end
      end
      if (load) begin
         rsp_word_ff <= {emit_last, emit_word_ff[emit_idx_ff]};
         rsp_index_ff <= emit_idx_ff;
         rsp_last_ff <= emit_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         emit_active_ff <= 1'b0;
         emit_idx_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take) begin
            count_ff <= pop_data.last ? '0 : count_in;
         end
         if (take && pop_data.last) begin
            emit_active_ff <= 1'b1;
            emit_idx_ff <= '0;
         end else if (load) begin
            if (emit_last) begin
               emit_active_ff <= 1'b0;
            end else begin
               emit_idx_ff <= emit_idx_ff + 1'b1;
            end
         end
         if (out_free) begin
            rsp_valid_ff <= emit_active_ff;
         end
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.packed_word = rsp_word_ff;
   assign rsp_bus.word_index = rsp_index_ff;
   assign rsp_bus.last_word = rsp_last_ff;

endmodule

@@ sv/zchar_word_encoder.sv @@
// Encodes one dictionary word, one ZSCII byte per req_bus transfer, into 5-bit
// Z-characters of the default alphabet and returns three packed 16-bit words on
// rsp_bus, bit 15 set on the third. A character is taken every cycle while the queue has
// room: the front end classifies it and queues it, and the back end appends its one to four
// codes to the entry. The closing character pads the entry and the three words leave in
// order from an output register; a further closing character waits in the queue until
// the last word of the previous entry has been loaded into that register. The queue holds
// four characters.
module zchar_word_encoder (
   input  logic      clock,
   input  logic      reset,
   zwe_req_if.sink   req_bus,
   zwe_rsp_if.source rsp_bus
);

   logic                   push_valid;
   logic                   push_ready;
   zwe_pkg::zwe_class_type push_data;
   logic                   pop_valid;
   logic                   pop_ready;
   zwe_pkg::zwe_class_type pop_data;

   zwe_front u_front (
      .req_bus    (req_bus),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   zwe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   zwe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_bus   (rsp_bus)
   );

   // The end mark and the last flag belong to the final word of an entry only.
   a_last_word_mark: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.last_word ==
         (rsp_bus.word_index == 2'(zwe_pkg::WORDS_PER_ENTRY - 1))) &&
         (rsp_bus.packed_word[15] == rsp_bus.last_word))
      else $error("end mark does not match word position");

   // Once an entry starts draining, its words follow without gaps.
   a_drain_gapless: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_word |=> rsp_bus.valid)
      else $error("gap inside an entry's words");

   // The word index advances by one within an entry.
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.ready && !rsp_bus.last_word |=>
         rsp_bus.word_index == $past(rsp_bus.word_index) + 2'd1)
      else $error("word index skipped");

endmodule
